### rtl/touch_position_spike_dropout_filter_top_assert.svh
// assertion macros for the touch position filter checker
`ifndef TOUCH_POSITION_SPIKE_DROPOUT_FILTER_TOP_ASSERT_SVH
`define TOUCH_POSITION_SPIKE_DROPOUT_FILTER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TPSDF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpsdf check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TPSDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpsdf check failed");

`endif

### rtl/tpsdf_pkg.sv
// shared types and constants for the touch position filter
`default_nettype none

package tpsdf_pkg;

    localparam int COORD_BITS_DEFAULT = 10;

    localparam int THRESH_BITS    = 10;
    localparam int MISS_BITS      = 8;
    localparam int SPIKE_BITS     = 4;
    localparam int CFG_DATA_BITS  = 10;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [THRESH_BITS-1:0] JUMP_THRESHOLD_RESET     = THRESH_BITS'(60);
    localparam logic [MISS_BITS-1:0]   MISS_LIMIT_RESET         = MISS_BITS'(10);
    localparam logic [SPIKE_BITS-1:0]  SPIKE_REJECT_LIMIT_RESET = SPIKE_BITS'(2);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_JUMP_THRESHOLD     = 2'd0,
        CFG_MISS_LIMIT         = 2'd1,
        CFG_SPIKE_REJECT_LIMIT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                     we;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } cfg_write_t;

endpackage

`default_nettype wire

### rtl/tpsdf_core.sv
// filter state, config registers and the per-sample update
`default_nettype none

module tpsdf_core
    import tpsdf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_write_t            cfg,
    input  wire logic                  step,
    input  wire logic [COORD_BITS-1:0] sample_x,
    input  wire logic [COORD_BITS-1:0] sample_y,
    input  wire logic [COORD_BITS-1:0] sample_pressure,
    output logic      [COORD_BITS-1:0] res_x,
    output logic      [COORD_BITS-1:0] res_y,
    output logic      [COORD_BITS-1:0] res_pressure,
    output logic                       res_present
);

    localparam int CMP_BITS = (COORD_BITS > THRESH_BITS) ? COORD_BITS : THRESH_BITS;

    logic [THRESH_BITS-1:0] jump_threshold_reg;
    logic [MISS_BITS-1:0]   miss_limit_reg;
    logic [SPIKE_BITS-1:0]  spike_limit_reg;

    logic                  last_valid_reg, last_valid_next;
    logic [COORD_BITS-1:0] last_x_reg, last_x_next;
    logic [COORD_BITS-1:0] last_y_reg, last_y_next;
    logic [SPIKE_BITS-1:0] spike_run_reg, spike_run_next;
    logic [MISS_BITS-1:0]  miss_run_reg, miss_run_next;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [CMP_BITS-1:0]   dx_wide;
    logic [CMP_BITS-1:0]   dy_wide;
    logic [CMP_BITS-1:0]   thr_wide;
    logic                  jump;
    logic                  spike;
    logic                  take;
    logic [MISS_BITS-1:0]  miss_bumped;

    always_comb
    begin
        dx       = (last_x_reg >= sample_x) ? (last_x_reg - sample_x) : (sample_x - last_x_reg);
        dy       = (last_y_reg >= sample_y) ? (last_y_reg - sample_y) : (sample_y - last_y_reg);
        dx_wide  = CMP_BITS'(dx);
        dy_wide  = CMP_BITS'(dy);
        thr_wide = CMP_BITS'(jump_threshold_reg);
        jump     = last_valid_reg && ((dx_wide >= thr_wide) || (dy_wide >= thr_wide));
        spike    = jump && (spike_run_reg < spike_limit_reg);
        take     = (sample_x != '0) && !spike;

        // saturates at the limit; a limit below the count leaves it as is
        miss_bumped = (miss_run_reg < miss_limit_reg) ? (miss_run_reg + MISS_BITS'(1))
                                                      : miss_run_reg;

        last_valid_next = last_valid_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        spike_run_next  = spike_run_reg;
        miss_run_next   = miss_run_reg;
        res_x           = sample_x;
        res_y           = sample_y;
        res_pressure    = sample_pressure;

        if (take)
        begin
            last_valid_next = 1'b1;
            last_x_next     = sample_x;
            last_y_next     = sample_y;
            spike_run_next  = '0;
            miss_run_next   = '0;
        end
        else
        begin
            miss_run_next = miss_bumped;
            if (miss_bumped < miss_limit_reg)
            begin
                res_x = last_x_reg;
                res_y = last_y_reg;
            end
            else
            begin
                // ball gone: zero the result and forget the point
                res_x           = '0;
                res_y           = '0;
                res_pressure    = '0;
                last_valid_next = 1'b0;
                last_x_next     = '0;
                last_y_next     = '0;
            end
            if (spike)
            begin
                spike_run_next = spike_run_reg + SPIKE_BITS'(1);
            end
        end

        res_present = miss_run_next < miss_limit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_threshold_reg <= JUMP_THRESHOLD_RESET;
            miss_limit_reg     <= MISS_LIMIT_RESET;
            spike_limit_reg    <= SPIKE_REJECT_LIMIT_RESET;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                CFG_JUMP_THRESHOLD:     jump_threshold_reg <= cfg.data[THRESH_BITS-1:0];
                CFG_MISS_LIMIT:         miss_limit_reg     <= cfg.data[MISS_BITS-1:0];
                CFG_SPIKE_REJECT_LIMIT: spike_limit_reg    <= cfg.data[SPIKE_BITS-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid_reg <= 1'b0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            spike_run_reg  <= '0;
            miss_run_reg   <= MISS_LIMIT_RESET;
        end
        else if (step)
        begin
            last_valid_reg <= last_valid_next;
            last_x_reg     <= last_x_next;
            last_y_reg     <= last_y_next;
            spike_run_reg  <= spike_run_next;
            miss_run_reg   <= miss_run_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tpsdf_skid.sv
// output register with one skid entry so the input stall is registered
`default_nettype none

module tpsdf_skid
    import tpsdf_pkg::*;
#(
    parameter int DATA_BITS = 3 * COORD_BITS_DEFAULT + 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_stall,
    input  wire logic [DATA_BITS-1:0] push_data,
    output logic                      pop_valid,
    input  wire logic                 pop_stall,
    output logic      [DATA_BITS-1:0] pop_data
);

    logic                 main_valid_reg, main_valid_next;
    logic [DATA_BITS-1:0] main_data_reg, main_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [DATA_BITS-1:0] skid_data_reg, skid_data_next;
    logic                 pop_fire;
    logic                 push_fire;

    assign push_stall = skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_data_reg;

    always_comb
    begin
        pop_fire        = main_valid_reg && !pop_stall;
        push_fire       = push_valid && !skid_valid_reg;
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            if (pop_fire)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push_fire)
        begin
            if (!main_valid_reg || pop_fire)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                // output is held, park the new transfer
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (pop_fire)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

### rtl/touch_position_spike_dropout_filter_top.sv
// top level of the touch position spike and dropout filter
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid / in_stall       sample_x, sample_y, sample_pressure
//   out      source     out_valid / out_stall     out_x, out_y, out_pressure, ball_present
//   cfg      sink       cfg_we                    cfg_index, cfg_data
//
// one sample per cycle while in_stall is low; the filter state and the
// output register, or skid entry if the output is held, update on the same edge
// in_stall is registered: it rises only when the output is held and one
// result already waits in the skid entry
// reset leaves defaults in the config registers and the ball marked absent
`default_nettype none

module touch_position_spike_dropout_filter_top
    import tpsdf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [COORD_BITS-1:0]     sample_x,
    input  wire logic [COORD_BITS-1:0]     sample_y,
    input  wire logic [COORD_BITS-1:0]     sample_pressure,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic      [COORD_BITS-1:0]     out_x,
    output logic      [COORD_BITS-1:0]     out_y,
    output logic      [COORD_BITS-1:0]     out_pressure,
    output logic                           ball_present,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int RES_BITS = 3 * COORD_BITS + 1;

    cfg_write_t            cfg;
    logic                  step;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;
    logic [COORD_BITS-1:0] res_pressure;
    logic                  res_present;
    logic [RES_BITS-1:0]   res_data;
    logic [RES_BITS-1:0]   out_data;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign step     = in_valid && !in_stall;
    assign res_data = {res_x, res_y, res_pressure, res_present};

    tpsdf_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .step            (step),
        .sample_x        (sample_x),
        .sample_y        (sample_y),
        .sample_pressure (sample_pressure),
        .res_x           (res_x),
        .res_y           (res_y),
        .res_pressure    (res_pressure),
        .res_present     (res_present)
    );

    tpsdf_skid #(
        .DATA_BITS (RES_BITS)
    ) u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_stall (in_stall),
        .push_data  (res_data),
        .pop_valid  (out_valid),
        .pop_stall  (out_stall),
        .pop_data   (out_data)
    );

    assign out_x        = out_data[RES_BITS-1 -: COORD_BITS];
    assign out_y        = out_data[2*COORD_BITS -: COORD_BITS];
    assign out_pressure = out_data[COORD_BITS -: COORD_BITS];
    assign ball_present = out_data[0];

endmodule

`default_nettype wire

### rtl/tpsdf_checker.sv
// port-level checks for the touch position filter, bound to the top level
`default_nettype none

`include "touch_position_spike_dropout_filter_top_assert.svh"

module tpsdf_checker
    import tpsdf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [COORD_BITS-1:0] out_x,
    input wire logic [COORD_BITS-1:0] out_y,
    input wire logic [COORD_BITS-1:0] out_pressure,
    input wire logic                  ball_present
);

    logic [3*COORD_BITS:0] out_payload;

    assign out_payload = {out_x, out_y, out_pressure, ball_present};

    `TPSDF_ASSERT_NEXT(a_out_valid_held, out_valid && out_stall, out_valid)

    `TPSDF_ASSERT_NEXT(a_out_payload_held, out_valid && out_stall, $stable(out_payload))

    // a parked result only exists behind a full output register
    `TPSDF_ASSERT_NOW(a_stall_needs_output, in_stall, out_valid)

    // one output transfer always frees the skid entry
    `TPSDF_ASSERT_NEXT(a_drain_frees_input, out_valid && !out_stall, !in_stall)

endmodule

bind touch_position_spike_dropout_filter_top tpsdf_checker #(
    .COORD_BITS (COORD_BITS)
) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_pressure (out_pressure),
    .ball_present (ball_present)
);

`default_nettype wire
